>>> sv/pwr_pkg.sv
`timescale 1ns / 1ps
package pwr_pkg;

	localparam int GRID_SIDE     = 64;
	localparam int GRID_BITS     = 6;
	localparam int GRID_CELLS    = GRID_SIDE * GRID_SIDE;
	localparam int GRID_AW       = 2 * GRID_BITS;
	localparam int PALETTE_DEPTH = 256;
	localparam int ANGLE_STEPS   = 1024;
	localparam int ANGLE_BITS    = 10;
	localparam int ANGLE_UW      = ANGLE_BITS + 2;
	localparam int ROM_AW        = ANGLE_BITS + 1;
	localparam int DIV_BITS      = ANGLE_BITS + 32;
	localparam int DIV_CYCLES    = DIV_BITS / 2;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	localparam logic [9:0] TRIGGER_RESET   = 10'd660;
	localparam logic [5:0] DEAD_ZONE_RESET = 6'd1;

	localparam logic [7:0] GREY_LEVEL  = 8'd100;
	localparam logic [7:0] OFF_GREEN   = 8'd128;

	// configuration register indexes
	localparam logic REG_TRIGGER_LEVEL = 1'b0;
	localparam logic REG_DEAD_ZONE     = 1'b1;

	typedef enum logic [1:0] {
		OP_SENSE  = 2'd0,
		OP_RENDER = 2'd1,
		OP_GRID_WR = 2'd2,
		OP_PAL_WR = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		JOB_GRID,
		JOB_PALETTE,
		JOB_RENDER
	} job_kind_t;

	typedef struct packed {
		job_kind_t          kind;
		logic [4:0]         led;
		logic signed [7:0]  radius;
		logic [31:0]        period;
		logic [31:0]        elapsed;
		logic [GRID_AW-1:0] addr;
		logic [23:0]        data;
	} job_t;

	typedef enum logic [3:0] {
		B_CLEAR,
		B_IDLE,
		B_DIV,
		B_SINY,
		B_SINX,
		B_SINX2,
		B_MUL,
		B_MAP,
		B_GRID,
		B_OUT
	} back_state_t;

	typedef logic [14:0] sine_rom_t [0:ANGLE_STEPS];

	// Q0.15 sine magnitude of m quarter steps, series in Q2.30
	function automatic logic [14:0] quarter_sine(input logic [ROM_AW-1:0] m);
		logic [63:0] t;
		logic [63:0] t2;
		logic [63:0] term;
		logic signed [63:0] sum;
		t = (64'(m) * HALF_PI_Q30) / ANGLE_STEPS;
		t2 = (t * t) >> 30;
		term = t;
		sum = signed'(t);
		for (int k = 1; k <= 7; k++) begin
			term = ((term * t2) >> 30) / 64'((2 * k) * (2 * k + 1));
			if (k % 2 == 1) begin
				sum = sum - signed'(term);
			end else begin
				sum = sum + signed'(term);
			end
		end
		if (sum < 0) begin
			sum = 0;
		end
		sum = (sum + 64'sd16384) >>> 15;
		if (sum > 64'sd32767) begin
			sum = 64'sd32767;
		end
		return sum[14:0];
	endfunction

	function automatic sine_rom_t build_sine_rom();
		sine_rom_t rom;
		for (int i = 0; i <= ANGLE_STEPS; i++) begin
			rom[i] = quarter_sine(ROM_AW'(i));
		end
		return rom;
	endfunction

endpackage

>>> sv/pwr_queue.sv
`timescale 1ns / 1ps
module pwr_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  pwr_pkg::job_t push_job,
	input  logic          pop,
	output pwr_pkg::job_t head,
	output logic          full,
	output logic          empty
);
	import pwr_pkg::*;

	job_t       slot_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] count_q;

	assign head  = slot_q[rd_q];
	assign full  = count_q == 2'd2;
	assign empty = count_q == 2'd0;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			if (push && !pop) count_q <= count_q + 2'd1;
			else if (pop && !push) count_q <= count_q - 2'd1;
		end
	end

endmodule

>>> sv/pwr_front.sv
`timescale 1ns / 1ps
module pwr_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [1:0]    opcode,
	input  logic [9:0]    sensor_sample,
	input  logic [31:0]   time_us,
	input  logic [4:0]    led_position,
	input  logic [11:0]   cell_address,
	input  logic [7:0]    cell_colour,
	input  logic [7:0]    palette_slot,
	input  logic [23:0]   palette_rgb,
	input  logic          cfg_we,
	input  logic          cfg_index,
	input  logic [9:0]    cfg_wdata,
	input  logic          q_full,
	input  logic          back_busy,
	output logic          push,
	output pwr_pkg::job_t push_job
);
	import pwr_pkg::*;

	logic [9:0]  trigger_q;
	logic [5:0]  dead_zone_q;
	logic [31:0] previous_q;
	logic [31:0] latest_q;
	logic        high_q;
	logic        accept;
	logic        sensing;
	logic        trig;
	logic        rise;
	logic [31:0] latest_n;
	logic [31:0] previous_n;
	op_t         op;

	assign op       = op_t'(opcode);
	assign in_ready = !q_full && !back_busy;
	assign accept   = in_valid && in_ready;
	assign sensing  = op == OP_SENSE || op == OP_RENDER;

	// rising crossing of the threshold marks a pulse
	assign trig       = sensor_sample > trigger_q;
	assign rise       = trig && !high_q;
	assign latest_n   = rise ? time_us : latest_q;
	assign previous_n = rise ? latest_q : previous_q;

	always_comb begin
		push = accept && op != OP_SENSE;
		push_job.led     = led_position;
		push_job.radius  = signed'(8'({3'b000, led_position}) + 8'({2'b00, dead_zone_q}) - 8'd1);
		push_job.period  = latest_n - previous_n;
		push_job.elapsed = time_us - latest_n;
		push_job.addr    = cell_address;
		push_job.data    = palette_rgb;
		case (op)
			OP_GRID_WR: begin
				push_job.kind = JOB_GRID;
				push_job.data = {16'h0000, cell_colour};
			end
			OP_PAL_WR: begin
				push_job.kind = JOB_PALETTE;
				push_job.addr = {4'h0, palette_slot};
			end
			default: push_job.kind = JOB_RENDER;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trigger_q <= TRIGGER_RESET;
			dead_zone_q <= DEAD_ZONE_RESET;
			previous_q <= 32'd0;
			latest_q <= 32'd0;
			high_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_TRIGGER_LEVEL: trigger_q <= cfg_wdata;
					REG_DEAD_ZONE:     dead_zone_q <= cfg_wdata[5:0];
					default: ;
				endcase
			end
			if (accept && sensing) begin
				high_q <= trig;
				latest_q <= latest_n;
				previous_q <= previous_n;
			end
		end
	end

endmodule

>>> sv/pwr_back.sv
`timescale 1ns / 1ps
module pwr_back (
	input  logic          clk,
	input  logic          arst_n,
	input  pwr_pkg::job_t head,
	input  logic          q_empty,
	output logic          pop,
	output logic          busy,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [4:0]    led_out,
	output logic [7:0]    red,
	output logic [7:0]    green,
	output logic [7:0]    blue,
	output logic          off_grid
);
	import pwr_pkg::*;

	localparam sine_rom_t SINE_ROM = build_sine_rom();

	back_state_t state_q, state_n;

	logic [GRID_AW-1:0] clr_cnt_q;
	logic [4:0]         div_cnt_q;

	logic [7:0]   grid_mem [GRID_CELLS];
	logic [23:0]  pal_mem  [PALETTE_DEPTH];

	logic [4:0]          led_q;
	logic signed [7:0]   radius_q;
	logic [31:0]         period_q;
	logic [DIV_BITS-1:0] num_q;
	logic [31:0]         rem_q;
	logic [ANGLE_BITS-1:0] phase_q;
	logic [14:0]         rom_q;
	logic signed [15:0]  sy_q;
	logic signed [15:0]  sx_q;
	logic signed [23:0]  px_s;
	logic signed [23:0]  py_s;
	logic [7:0]          grid_q;
	logic [23:0]         pal_q;
	logic                out_valid_q;
	logic [4:0]          led_out_q;
	logic [7:0]          red_q, green_q, blue_q;
	logic                off_q;

	logic               grid_we;
	logic [GRID_AW-1:0] grid_wa;
	logic [7:0]         grid_wd;
	logic               pal_we;
	logic               out_free;
	logic               out_load;
	logic               head_render;

	logic [32:0] r1, r2;
	logic [31:0] r1b;
	logic        ge1, ge2;
	logic [ANGLE_UW-1:0] u_y, u_x;
	logic [ROM_AW-1:0]   rom_addr;
	logic signed [23:0]  tx, ty;
	logic signed [8:0]   x, y;
	logic signed [9:0]   col, row;
	logic                off;
	logic [7:0]          r_c, g_c, b_c;

	function automatic logic [ROM_AW-1:0] fold(input logic [ANGLE_UW-1:0] u);
		logic [ROM_AW-1:0] m;
		m = {1'b0, u[ANGLE_BITS-1:0]};
		if (u[ANGLE_BITS]) begin
			m = ROM_AW'(ANGLE_STEPS) - m;
		end
		return m;
	endfunction

	function automatic logic signed [15:0] apply_sign(input logic [14:0] mag, input logic neg);
		logic signed [15:0] v;
		v = signed'({1'b0, mag});
		return neg ? -v : v;
	endfunction

	// restoring divide, two quotient bits a cycle
	always_comb begin
		r1 = {rem_q, num_q[DIV_BITS-1]};
		ge1 = r1 >= {1'b0, period_q};
		r1b = ge1 ? 32'(r1 - {1'b0, period_q}) : r1[31:0];
		r2 = {r1b, num_q[DIV_BITS-2]};
		ge2 = r2 >= {1'b0, period_q};
	end

	// angle plus a quarter turn for y, another quarter for x
	assign u_y = {phase_q, 2'b00} + ANGLE_UW'(ANGLE_STEPS);
	assign u_x = u_y + ANGLE_UW'(ANGLE_STEPS);

	// truncate toward zero on the Q1.15 scale
	always_comb begin
		tx = px_s + (px_s[23] ? 24'sd32767 : 24'sd0);
		ty = py_s + (py_s[23] ? 24'sd32767 : 24'sd0);
		x = tx[23:15];
		y = ty[23:15];
		col = 10'(x) + 10'sd32;
		row = 10'sd32 - 10'(y);
		off = col[9:GRID_BITS] != '0 || row[9:GRID_BITS] != '0;
	end

	always_comb begin
		if (off) begin
			r_c = 8'd0; g_c = OFF_GREEN; b_c = 8'd0;
		end else if (grid_q == 8'd0) begin
			r_c = GREY_LEVEL; g_c = GREY_LEVEL; b_c = GREY_LEVEL;
		end else begin
			r_c = pal_q[23:16]; g_c = pal_q[15:8]; b_c = pal_q[7:0];
		end
	end

	assign out_free    = !out_valid_q || out_ready;
	assign head_render = head.kind == JOB_RENDER;

	always_comb begin
		state_n = state_q;
		case (state_q)
			B_CLEAR: if (clr_cnt_q == '1) state_n = B_IDLE;
			B_IDLE: begin
				if (!q_empty && head_render) begin
					state_n = (head.period == 32'd0) ? B_SINY : B_DIV;
				end
			end
			B_DIV:   if (div_cnt_q == 5'(DIV_CYCLES - 1)) state_n = B_SINY;
			B_SINY:  state_n = B_SINX;
			B_SINX:  state_n = B_SINX2;
			B_SINX2: state_n = B_MUL;
			B_MUL:   state_n = B_MAP;
			B_MAP:   state_n = B_GRID;
			B_GRID:  state_n = B_OUT;
			B_OUT:   if (out_free) state_n = B_IDLE;
			default: state_n = B_IDLE;
		endcase
	end

	always_comb begin
		busy = state_q == B_CLEAR;
		pop = state_q == B_IDLE && !q_empty;
		grid_we = busy || (pop && head.kind == JOB_GRID);
		grid_wa = busy ? clr_cnt_q : head.addr;
		grid_wd = busy ? 8'd0 : head.data[7:0];
		pal_we = pop && head.kind == JOB_PALETTE;
		out_load = state_q == B_OUT && out_free;
		rom_addr = (state_q == B_SINY) ? fold(u_y) : fold(u_x);
	end

	always_ff @(posedge clk) begin
		if (grid_we) grid_mem[grid_wa] <= grid_wd;
		grid_q <= grid_mem[{row[GRID_BITS-1:0], col[GRID_BITS-1:0]}];
	end

	always_ff @(posedge clk) begin
		if (pal_we) pal_mem[head.addr[7:0]] <= head.data;
		pal_q <= pal_mem[grid_q];
	end

	always_ff @(posedge clk) begin
		rom_q <= SINE_ROM[rom_addr];
		if (pop && head_render) begin
			led_q <= head.led;
			radius_q <= head.radius;
			period_q <= head.period;
			num_q <= {head.elapsed, ANGLE_BITS'(0)};
			rem_q <= 32'd0;
			phase_q <= '0;
		end
		if (state_q == B_DIV) begin
			num_q <= num_q << 2;
			rem_q <= ge2 ? 32'(r2 - {1'b0, period_q}) : r2[31:0];
			phase_q <= {phase_q[ANGLE_BITS-3:0], ge1, ge2};
		end
		if (state_q == B_SINX) sy_q <= apply_sign(rom_q, u_y[ANGLE_UW-1]);
		if (state_q == B_SINX2) sx_q <= apply_sign(rom_q, u_x[ANGLE_UW-1]);
		if (state_q == B_MUL) begin
			px_s <= 24'(radius_q) * 24'(sx_q);
			py_s <= 24'(radius_q) * 24'(sy_q);
		end
		if (out_load) begin
			led_out_q <= led_q;
			red_q <= r_c;
			green_q <= g_c;
			blue_q <= b_c;
			off_q <= off;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_CLEAR;
			clr_cnt_q <= '0;
			div_cnt_q <= 5'd0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (busy) clr_cnt_q <= clr_cnt_q + 1'b1;
			if (state_q == B_DIV) div_cnt_q <= div_cnt_q + 5'd1;
			else div_cnt_q <= 5'd0;
			if (out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign led_out   = led_out_q;
	assign red       = red_q;
	assign green     = green_q;
	assign blue      = blue_q;
	assign off_grid  = off_q;

endmodule

>>> sv/pov_wheel_polar_renderer.sv
`timescale 1ns / 1ps
// channel  | direction | tdata (low bit up)                            | tuser
// s_*      | in        | sample, time_us, led, cell addr, cell colour, | opcode
//          |           | palette slot, palette rgb (99 bits, pad 104)  |
// m_*      | out       | led_out, red, green, blue (29 bits, pad 32)   | off_grid
// cfg_*    | in        | index 0 trigger_level, 1 dead_zone_leds       | -
//
// Grid and palette writes take effect as the back end pops them; a render runs
// the 42-bit period divide, two quotient bits a cycle, unless period is zero.
// After reset the 4096-cell grid is cleared, one cell a cycle;
// s_tready stays low during that pass. A two-word queue separates the input
// side from the renderer, and the output register frees the renderer while
// a finished word waits on m_tready.
module pov_wheel_polar_renderer (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [103:0] s_tdata,   // sensor_sample, time_us, led_position, cell_address,
	                                // cell_colour, palette_slot, palette_rgb
	input  logic [1:0]   s_tuser,   // opcode
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [31:0]  m_tdata,   // led_out, red, green, blue
	output logic [0:0]   m_tuser,   // off_grid
	input  logic         cfg_we,
	input  logic         cfg_index,
	input  logic [9:0]   cfg_wdata
);
	import pwr_pkg::*;

	job_t       push_job;
	job_t       head;
	logic       push;
	logic       pop;
	logic       q_full;
	logic       q_empty;
	logic       busy;
	logic [4:0] led_out;
	logic [7:0] red, green, blue;
	logic       off_grid;

	pwr_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (s_tvalid),
		.in_ready      (s_tready),
		.opcode        (s_tuser),
		.sensor_sample (s_tdata[9:0]),
		.time_us       (s_tdata[41:10]),
		.led_position  (s_tdata[46:42]),
		.cell_address  (s_tdata[58:47]),
		.cell_colour   (s_tdata[66:59]),
		.palette_slot  (s_tdata[74:67]),
		.palette_rgb   (s_tdata[98:75]),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.q_full        (q_full),
		.back_busy     (busy),
		.push          (push),
		.push_job      (push_job)
	);

	pwr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.full     (q_full),
		.empty    (q_empty)
	);

	pwr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_empty   (q_empty),
		.pop       (pop),
		.busy      (busy),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.led_out   (led_out),
		.red       (red),
		.green     (green),
		.blue      (blue),
		.off_grid  (off_grid)
	);

	assign m_tdata = {3'b000, blue, green, red, led_out};
	assign m_tuser = off_grid;

endmodule
